FILE: hw/rtl/acrms_pkg.sv
`timescale 1ns / 1ps
package acrms_pkg;

  localparam int unsigned HistoryDepthDefault = 8;
  localparam int unsigned MaxWindowDefault    = 4096;

  localparam logic [15:0] OffsetReset      = 16'd32768;
  localparam logic [15:0] NoiseReset       = 16'd0;
  localparam logic [23:0] SensReset        = 24'd262144;
  localparam logic [12:0] WindowReset      = 13'd1000;
  localparam logic [15:0] IntervalReset    = 16'd200;
  localparam logic [15:0] NominalReset     = 16'd50000;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    RegOffset   = 3'd0,
    RegNoise    = 3'd1,
    RegSens     = 3'd2,
    RegWindow   = 3'd3,
    RegInterval = 3'd4,
    RegNominal  = 3'd5
  } cfg_reg_e;

  localparam logic [18:0] GateFloor    = 19'd160;
  localparam logic [16:0] VoltFloor    = 17'd800;
  localparam logic [31:0] FreqLowMhz2  = 32'd90000;
  localparam logic [31:0] FreqHighMhz2 = 32'd110000;
  localparam logic [31:0] NanoPerSec   = 32'd1000000000;

endpackage

FILE: hw/rtl/ac_rms_frequency_meter.sv
`timescale 1ns / 1ps
// Sample items inside a window are taken one per cycle. The last sample of a window
// holds the input off for a 64-step divide for the mean square, the root, two voltage
// steps and one output step; one test step more when a frequency is tested and rejected,
// and when it enters the ring also a second 64-step divide, a ring write and a ring sum;
// a result left waiting in the output register stretches this further.
// Reset (asynchronous, active low) loads the register defaults and fills the ring.
module ac_rms_frequency_meter import acrms_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDefault,
  parameter int unsigned MAX_WINDOW    = MaxWindowDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [11:0]         adc_sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         voltage_rms_q4_o,
  output logic [15:0]         frequency_mhz_o,
  output logic                freq_updated_o,
  output logic [11:0]         min_sample_o,
  output logic [11:0]         max_sample_o,
  output logic [12:0]         crossings_o
);

  localparam int unsigned PtrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SumW = 16 + PtrW + 1;
  localparam int unsigned WinW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DivW = 64;

  // The ring average divides by a reciprocal that is exact over the whole sum range.
  localparam int unsigned AvgShift = SumW + PtrW;
  localparam int unsigned AvgPW    = 2 * SumW + 2;
  localparam logic [63:0] AvgRecip =
      ((64'd1 << AvgShift) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);

  typedef enum logic [9:0] {
    StAcc    = 10'b0000000001,
    StMsDiv  = 10'b0000000010,
    StSqrt   = 10'b0000000100,
    StVolt   = 10'b0000001000,
    StFrqMul = 10'b0000010000,
    StFrqDiv = 10'b0000100000,
    StSum    = 10'b0001000000,
    StAvg    = 10'b0010000000,
    StOut    = 10'b0100000000,
    StFill   = 10'b1000000000
  } state_e;

  state_e state_q;

  logic [15:0] offset_q, noise_q, interval_q;
  logic [23:0] sens_q;
  logic [12:0] window_q;

  logic        seeded_q, above_q;
  logic [WinW-1:0] count_q;
  logic [47:0] sq_sum_q;
  logic [11:0] min_q, max_q;
  logic [12:0] cross_q, first_q, last_q;
  logic [15:0] ring_q [HISTORY_DEPTH];
  logic [PtrW-1:0] ptr_q, sweep_q;
  logic [15:0] avg_q;
  logic [SumW-1:0] sum_q;

  // Shared restoring divider / root / multiply registers.
  logic [DivW-1:0] num_q, den_q, quo_q, rem_q;
  logic [6:0]  step_q;
  logic [63:0] prod_q;
  logic [31:0] rms_q;
  logic [15:0] volt_q;
  logic        upd_q;

  // Output register.
  logic        ovalid_q;
  logic [15:0] o_volt_q, o_freq_q;
  logic        o_upd_q;
  logic [11:0] o_min_q, o_max_q;
  logic [12:0] o_cross_q;

  wire in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StAcc);

  // Effective window length.
  logic [WinW-1:0] win_len;
  always_comb begin
    if (window_q == 13'd0) win_len = WinW'(1);
    else if ({{(32-13){1'b0}}, window_q} > 32'(MAX_WINDOW)) win_len = WinW'(MAX_WINDOW);
    else win_len = WinW'(window_q);
  end

  logic        above;
  logic [12:0] roff;
  logic signed [13:0] dev;
  logic [27:0] dev_sq;
  assign above  = {adc_sample_i, 4'd0} > offset_q;
  assign roff   = 13'(({1'b0, offset_q} + 17'd8) >> 4);
  assign dev    = $signed({2'b0, adc_sample_i}) - $signed({1'b0, roff});
  assign dev_sq = 28'($signed(28'(dev)) * $signed(28'(dev)));

  // Divider step.
  logic [DivW:0] trial;
  logic [DivW-1:0] rem_sh;
  assign rem_sh = {rem_q[DivW-2:0], num_q[DivW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_q};

  // Root step (bit-pair, operand in num_q, root in rms_q, remainder in rem_q).
  logic [33:0] rt_rem, rt_try;
  assign rt_rem = {rem_q[31:0], num_q[63:62]};
  assign rt_try = {rms_q, 2'b01};

  logic [12:0] span;
  assign span = last_q - first_q;

  logic [SumW-1:0]  avg_x;
  logic [AvgPW-1:0] avg_p;
  assign avg_x = sum_q + SumW'(HISTORY_DEPTH / 2);
  assign avg_p = AvgPW'(avg_x) * AvgPW'(AvgRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StAcc;
      offset_q <= OffsetReset; noise_q <= NoiseReset; sens_q <= SensReset;
      window_q <= WindowReset; interval_q <= IntervalReset;
      seeded_q <= 1'b0; above_q <= 1'b0; count_q <= '0; sq_sum_q <= '0;
      min_q <= 12'hFFF; max_q <= '0; cross_q <= '0; first_q <= '0; last_q <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) ring_q[i] <= NominalReset;
      ptr_q <= '0; avg_q <= NominalReset; sweep_q <= '0; sum_q <= '0;
      ovalid_q <= 1'b0; upd_q <= 1'b0; step_q <= '0;
    end else begin
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegOffset:   offset_q   <= cfg_data_i[15:0];
          RegNoise:    noise_q    <= cfg_data_i[15:0];
          RegSens:     sens_q     <= cfg_data_i;
          RegWindow:   window_q   <= cfg_data_i[12:0];
          RegInterval: interval_q <= cfg_data_i[15:0];
          RegNominal: begin
            for (int i = 0; i < HISTORY_DEPTH; i++) ring_q[i] <= cfg_data_i[15:0];
            ptr_q <= '0;
            avg_q <= cfg_data_i[15:0];
          end
          default: ;
        endcase
      end
      case (state_q)
        StAcc: if (in_acc) begin
          if (!seeded_q) begin
            seeded_q <= 1'b1; above_q <= above; count_q <= '0; sq_sum_q <= '0;
            min_q <= 12'hFFF; max_q <= '0; cross_q <= '0; first_q <= '0; last_q <= '0;
          end else begin
            if (adc_sample_i < min_q) min_q <= adc_sample_i;
            if (adc_sample_i > max_q) max_q <= adc_sample_i;
            sq_sum_q <= sq_sum_q + 48'(dev_sq);
            if (above != above_q) begin
              if (cross_q == 13'd0) first_q <= 13'(count_q);
              last_q <= 13'(count_q);
              cross_q <= cross_q + 13'd1;
              above_q <= above;
            end
            count_q <= count_q + WinW'(1);
            if (count_q + WinW'(1) >= win_len) begin
              seeded_q <= 1'b0;
              num_q <= {8'd0, sq_sum_q + 48'(dev_sq), 8'd0};
              den_q <= DivW'(count_q + WinW'(1));
              rem_q <= '0; quo_q <= '0; step_q <= '0;
              state_q <= StMsDiv;
            end
          end
        end
        StMsDiv: begin
          num_q <= {num_q[DivW-2:0], 1'b0};
          if (!trial[DivW]) begin
            rem_q <= trial[DivW-1:0]; quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh; quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
          step_q <= step_q + 7'd1;
          if (step_q == 7'd63) state_q <= StSqrt;
        end
        StSqrt: begin
          if (step_q == 7'd0 + 7'd64) begin
            num_q <= quo_q; rem_q <= '0; rms_q <= '0; step_q <= 7'd1;
          end else begin
            num_q <= {num_q[61:0], 2'b00};
            if (rt_rem >= rt_try) begin
              rem_q <= DivW'(rt_rem - rt_try); rms_q <= {rms_q[30:0], 1'b1};
            end else begin
              rem_q <= DivW'(rt_rem); rms_q <= {rms_q[30:0], 1'b0};
            end
            step_q <= step_q + 7'd1;
            if (step_q == 7'd32) begin
              state_q <= StVolt;
              step_q <= '0;
            end
          end
        end
        StVolt: begin
          if (step_q == 7'd0) begin
            prod_q <= 64'(rms_q) * 64'(sens_q);
            step_q <= 7'd1;
          end else begin
            logic [43:0] v;
            v = 44'((prod_q + 64'd524288) >> 20);
            if (64'(rms_q) < 64'(((19'(noise_q) * 19'd6) < GateFloor) ? GateFloor
                                  : (19'(noise_q) * 19'd6)))
              volt_q <= '0;
            else if (v < 44'(VoltFloor)) volt_q <= '0;
            else if (v > 44'd65535) volt_q <= 16'hFFFF;
            else volt_q <= v[15:0];
            upd_q <= 1'b0;
            step_q <= '0;
            prod_q <= 64'(span) * 64'(interval_q);
            if (cross_q >= 13'd4 && last_q > first_q && interval_q != 16'd0)
              state_q <= StFrqMul;
            else
              state_q <= StOut;
          end
        end
        StFrqMul: begin
          // prod_q holds D; test range and set up (num + D) / 2D.
          logic [63:0] nm;
          nm = 64'(cross_q - 13'd1) * 64'(NanoPerSec);
          if (nm >= 64'(FreqLowMhz2) * prod_q && nm <= 64'(FreqHighMhz2) * prod_q) begin
            num_q <= nm + prod_q; den_q <= {prod_q[62:0], 1'b0};
            rem_q <= '0; quo_q <= '0; step_q <= '0;
            state_q <= StFrqDiv;
          end else state_q <= StOut;
        end
        StFrqDiv: begin
          num_q <= {num_q[DivW-2:0], 1'b0};
          if (!trial[DivW]) begin
            rem_q <= trial[DivW-1:0]; quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh; quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
          step_q <= step_q + 7'd1;
          if (step_q == 7'd63) state_q <= StFill;
        end
        StFill: begin
          ring_q[ptr_q] <= quo_q[15:0];
          ptr_q <= (32'(ptr_q) == HISTORY_DEPTH - 1) ? '0 : ptr_q + PtrW'(1);
          upd_q <= 1'b1; sweep_q <= '0; sum_q <= '0;
          state_q <= StSum;
        end
        StSum: begin
          sum_q <= sum_q + SumW'(ring_q[sweep_q]);
          sweep_q <= sweep_q + PtrW'(1);
          if (32'(sweep_q) == HISTORY_DEPTH - 1) state_q <= StAvg;
        end
        StAvg: begin
          avg_q <= avg_p[AvgShift +: 16];
          state_q <= StOut;
        end
        StOut: if (!ovalid_q || !out_stall_i) begin
          ovalid_q <= 1'b1;
          o_volt_q <= volt_q; o_freq_q <= avg_q; o_upd_q <= upd_q;
          o_min_q <= min_q; o_max_q <= max_q; o_cross_q <= cross_q;
          state_q <= StAcc;
        end
        default: state_q <= StAcc;
      endcase
      if (state_q == StMsDiv && step_q == 7'd63) step_q <= 7'd64;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign voltage_rms_q4_o = o_volt_q;
  assign frequency_mhz_o  = o_freq_q;
  assign freq_updated_o   = o_upd_q;
  assign min_sample_o     = o_min_q;
  assign max_sample_o     = o_max_q;
  assign crossings_o      = o_cross_q;

endmodule

FILE: dv/tb_ac_rms_frequency_meter.sv
`timescale 1ns / 1ps
module tb_ac_rms_frequency_meter;
  import acrms_pkg::*;

  // Index codes beyond the defined registers; writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;
  localparam int unsigned RingDepth   = 8;
  localparam int unsigned WindowCap   = 4096;
  localparam int unsigned CloseCycles = 300;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StuckLimit  = 20000;

  typedef struct packed {
    logic [15:0] volt;
    logic [15:0] freq;
    logic        upd;
    logic [11:0] mn;
    logic [11:0] mx;
    logic [12:0] cr;
  } window_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [11:0]         adc_sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [15:0]         voltage_rms_q4_o;
  logic [15:0]         frequency_mhz_o;
  logic                freq_updated_o;
  logic [11:0]         min_sample_o;
  logic [11:0]         max_sample_o;
  logic [12:0]         crossings_o;

  ac_rms_frequency_meter u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the registers and window state.
  logic [15:0] m_offset, m_noise, m_interval, m_nominal;
  logic [23:0] m_sens;
  logic [12:0] m_window;
  bit          m_seeded, m_above;
  int unsigned m_count, m_min, m_max, m_cross, m_first, m_last;
  longint unsigned m_sqsum;
  logic [15:0] m_ring [RingDepth];
  int unsigned m_ptr;
  logic [15:0] m_avg;

  logic [11:0] directed_samples [10] = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0,
                                         12'd2048, 12'd2047, 12'd2049, 12'd2048, 12'd4095};

  window_result_t expected_windows[$];
  logic [11:0]    pending_samples[$];
  int unsigned    errors = 0;
  int unsigned    sender_idle_pct = 37;
  int unsigned    receiver_idle_pct = 37;
  int unsigned    hold_req = 0, hold_ack = 0, hold_left = 0;
  int unsigned    stuck = 0;
  bit             took_sample;

  function automatic void refill_ring(logic [15:0] v);
    for (int i = 0; i < RingDepth; i++) m_ring[i] = v;
    m_ptr = 0;
    m_avg = v;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    case (idx)
      RegOffset:   m_offset = d[15:0];
      RegNoise:    m_noise = d[15:0];
      RegSens:     m_sens = d[23:0];
      RegWindow:   m_window = d[12:0];
      RegInterval: m_interval = d[15:0];
      RegNominal: begin
        m_nominal = d[15:0];
        refill_ring(m_nominal);
      end
      default: ;
    endcase
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int b = 20; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r = r | (64'd1 << b);
    return r;
  endfunction

  function automatic int unsigned eff_window();
    if (m_window == 13'd0) return 1;
    if (32'(m_window) > WindowCap) return WindowCap;
    return 32'(m_window);
  endfunction

  function automatic void predict_sample(logic [11:0] s);
    bit above;
    longint signed dev;
    longint unsigned rms, thr, v, d, num, f, sum;
    window_result_t r;
    above = (32'(s) * 16) > 32'(m_offset);
    if (!m_seeded) begin
      m_seeded = 1; m_above = above; m_count = 0; m_sqsum = 0;
      m_min = 4095; m_max = 0; m_cross = 0; m_first = 0; m_last = 0;
      return;
    end
    if (32'(s) < m_min) m_min = 32'(s);
    if (32'(s) > m_max) m_max = 32'(s);
    dev = longint'(s) - longint'((32'(m_offset) + 8) >> 4);
    m_sqsum += longint'(dev * dev);
    if (above != m_above) begin
      if (m_cross == 0) m_first = m_count;
      m_last = m_count;
      m_cross++;
      m_above = above;
    end
    m_count++;
    if (m_count < eff_window()) return;
    m_seeded = 0;
    rms = root_floor((m_sqsum * 256) / 64'(m_count));
    thr = 64'(m_noise) * 6;
    if (thr < 160) thr = 160;
    v = (rms < thr) ? 0 : (rms * 64'(m_sens) + (64'd1 << 19)) >> 20;
    if (v < 800) v = 0;
    if (v > 65535) v = 65535;
    r.upd = 0;
    if (m_cross >= 4 && m_last > m_first) begin
      d = 64'(m_last - m_first) * 64'(m_interval);
      num = 64'(m_cross - 1) * 64'd1000000000;
      if (d != 0 && num >= 90000 * d && num <= 110000 * d) begin
        f = (num + d) / (2 * d);
        m_ring[m_ptr] = f[15:0];
        m_ptr = (m_ptr + 1) % RingDepth;
        sum = 0;
        for (int i = 0; i < RingDepth; i++) sum += 64'(m_ring[i]);
        m_avg = 16'((sum + RingDepth / 2) / RingDepth);
        r.upd = 1;
      end
    end
    r.volt = v[15:0];
    r.freq = m_avg;
    r.mn = m_min[11:0];
    r.mx = m_max[11:0];
    r.cr = m_cross[12:0];
    expected_windows.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Sample side: acceptance is seen at the rising edge, a new item is offered at the falling one.
  always @(posedge clk_i) begin
    took_sample <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) predict_sample(adc_sample_i);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took_sample)) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid_i <= 1'b1;
        adc_sample_i <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    window_result_t w;
    if (out_valid_o && !out_stall_i) begin
      if (expected_windows.size() == 0) begin
        report_mismatch("result with no window pending", 64'd1, 64'd0);
      end else begin
        w = expected_windows.pop_front();
        if (voltage_rms_q4_o !== w.volt)
          report_mismatch("voltage", longint'(voltage_rms_q4_o), longint'(w.volt));
        if (frequency_mhz_o !== w.freq)
          report_mismatch("frequency", longint'(frequency_mhz_o), longint'(w.freq));
        if (freq_updated_o !== w.upd)
          report_mismatch("freq_updated", longint'(freq_updated_o), longint'(w.upd));
        if (min_sample_o !== w.mn)
          report_mismatch("min", longint'(min_sample_o), longint'(w.mn));
        if (max_sample_o !== w.mx)
          report_mismatch("max", longint'(max_sample_o), longint'(w.mx));
        if (crossings_o !== w.cr)
          report_mismatch("crossings", longint'(crossings_o), longint'(w.cr));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > StuckLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    apply_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Let every queued item go in and every window close before touching registers.
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_windows.size() != 0)
      @(posedge clk_i);
    repeat (CloseCycles) @(posedge clk_i);
  endtask

  function automatic logic [11:0] clip(int v);
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return v[11:0];
  endfunction

  // One window's worth: a square wave of period 20 samples around the offset, or noise.
  function automatic void queue_window(bit noisy);
    int centre, amp, phase, jitter;
    centre = (32'(m_offset) + 8) >> 4;
    amp = $urandom_range(2000, 30);
    phase = $urandom_range(19);
    jitter = $urandom_range(3);
    for (int i = 0; i <= eff_window(); i++) begin
      if (noisy)
        pending_samples.push_back(12'($urandom));
      else
        pending_samples.push_back(clip(((i + phase) % 20 < 10 ? centre + amp : centre - amp)
                                       + $urandom_range(2 * jitter) - jitter));
    end
  endfunction

  int unsigned sent;
  int unsigned nwin;

  initial begin
    m_offset = OffsetReset; m_noise = NoiseReset; m_sens = SensReset;
    m_window = WindowReset; m_interval = IntervalReset; m_nominal = NominalReset;
    m_seeded = 0; m_above = 0; m_count = 0; m_sqsum = 0; m_min = 4095; m_max = 0;
    m_cross = 0; m_first = 0; m_last = 0;
    refill_ring(NominalReset);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme samples, tiny windows, a zero-length window, spare indexes.
    write_reg(RegWindow, 24'd4);
    write_reg(RegSpare6, 24'hFFFFFF);
    write_reg(RegSpare7, 24'h123456);
    foreach (directed_samples[i]) pending_samples.push_back(directed_samples[i]);
    drain();
    write_reg(RegWindow, 24'd0);
    write_reg(RegSens, 24'hFFFFFF);
    for (int i = 0; i < 4; i++) pending_samples.push_back(i[0] ? 12'd4095 : 12'd0);
    drain();
    write_reg(RegWindow, 24'd200);
    write_reg(RegInterval, 24'd1000);
    write_reg(RegNominal, 24'd45000);
    queue_window(0);
    drain();

    // Random phases.
    sent = 0;
    for (int ph = 0; sent < 1000; ph++) begin
      case ($urandom_range(5))
        0: write_reg(RegOffset, 24'd0);
        1: write_reg(RegOffset, 24'h00FFFF);
        default: write_reg(RegOffset, 24'($urandom_range(40000, 25000)));
      endcase
      case ($urandom_range(7))
        0: write_reg(RegNoise, 24'h00FFFF);
        1: write_reg(RegNoise, 24'($urandom_range(65535)));
        default: write_reg(RegNoise, 24'($urandom_range(60)));
      endcase
      case ($urandom_range(5))
        0: write_reg(RegSens, 24'd0);
        1: write_reg(RegSens, 24'hFFFFFF);
        default: write_reg(RegSens, 24'($urandom_range(24'hFFFFFF)));
      endcase
      write_reg(RegWindow, 24'(($urandom_range(9) == 0) ? $urandom_range(8191) % 200
                                                        : $urandom_range(64, 1)));
      case ($urandom_range(7))
        0: write_reg(RegInterval, 24'd0);
        1: write_reg(RegInterval, 24'h00FFFF);
        default: write_reg(RegInterval, 24'($urandom_range(1111, 909)));
      endcase
      if ($urandom_range(3) == 0) write_reg(RegNominal, 24'($urandom_range(55000, 45000)));
      sender_idle_pct = (ph % 7 == 3) ? 0 : 37;
      receiver_idle_pct = (ph % 7 == 3) ? 0 : 37;
      if (ph == 1) begin
        // Receiver holds off while two-sample windows keep coming.
        write_reg(RegWindow, 24'd1);
        hold_req++;
        for (int i = 0; i < 40; i++) pending_samples.push_back(12'($urandom));
        sent += 40;
      end
      nwin = $urandom_range(6, 1);
      for (int k = 0; k < nwin; k++) begin
        queue_window($urandom_range(3) == 0);
        sent += eff_window() + 1;
      end
      drain();
    end
    sender_idle_pct = 37;
    receiver_idle_pct = 37;
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
